/* rtl/tft_pkg.sv */
// Package for the TLB / FIFO page translator.
// Holds the controller-to-datapath command and status types and fixed field widths.
// No dependencies.
package tft_pkg;

    localparam int VA_W   = 16;
    localparam int PA_W   = 15;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic finish;
        logic evict;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic need_evict;
        logic out_free;
    } t_status;

endpackage

/* rtl/tft_ctrl.sv */
// Sequencer for the TLB / FIFO page translator.
// Steps through page-map clear, accept, lookup/update and eviction write-back.
// Depends on tft_pkg.
module tft_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tft_pkg::t_status i_status,
    output tft_pkg::t_cmd   o_cmd,
    output logic            o_in_stall
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_EVICT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = i_status.need_evict ? S_EVICT : S_IDLE;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/tft_dp.sv */
// Datapath for the TLB / FIFO page translator.
// Holds the TLB registers, page-map and frame-owner memories, counters and result register.
// Depends on tft_pkg.
module tft_dp #(
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 128,
    parameter int PAGE_BYTES  = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tft_pkg::t_cmd              i_cmd,
    output tft_pkg::t_status           o_status,
    input  logic [tft_pkg::VA_W-1:0]   i_virtual_address,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic [tft_pkg::PA_W-1:0]   o_physical_address,
    output logic                       o_tlb_hit,
    output logic                       o_page_fault,
    output logic [tft_pkg::SLOT_W-1:0] o_tlb_slot,
    output logic                       o_evicted_valid,
    output logic [tft_pkg::CNT_W-1:0]  o_hit_total,
    output logic [tft_pkg::CNT_W-1:0]  o_fault_total
);

    localparam int PAGE_COUNT = 65536 / PAGE_BYTES;
    localparam int OFS_W      = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = tft_pkg::VA_W - OFS_W;
    localparam int TLB_W      = $clog2(TLB_ENTRIES);
    localparam int FRAME_W    = $clog2(FRAME_COUNT);
    localparam int PM_W       = FRAME_W + 1;
    localparam logic [TLB_W-1:0]   TLB_LAST   = TLB_W'(TLB_ENTRIES - 1);
    localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);
    localparam logic [PAGE_W-1:0]  PAGE_LAST  = PAGE_W'(PAGE_COUNT - 1);

    // memories
    logic [PM_W-1:0]   r_page_map   [PAGE_COUNT];
    logic [PAGE_W-1:0] r_frame_owner[FRAME_COUNT];

    // TLB
    logic                r_tlb_valid[TLB_ENTRIES];
    logic [PAGE_W-1:0]   r_tlb_tag  [TLB_ENTRIES];
    logic [FRAME_W-1:0]  r_tlb_frame[TLB_ENTRIES];
    logic [TLB_W-1:0]    r_tptr;

    logic [FRAME_W-1:0]  r_fptr;
    logic                r_wrap;
    logic [PAGE_W-1:0]   r_clr;
    logic [tft_pkg::CNT_W-1:0] r_hit_cnt;
    logic [tft_pkg::CNT_W-1:0] r_fault_cnt;

    // per-transaction
    logic [tft_pkg::VA_W-1:0] r_va;
    logic [PM_W-1:0]          r_pm_rd;
    logic [PAGE_W-1:0]        r_own_rd;
    logic [TLB_ENTRIES-1:0]   r_match;

    logic                        r_out_valid;
    logic [tft_pkg::PA_W-1:0]    r_out_pa;
    logic                        r_out_hit;
    logic                        r_out_fault;
    logic [tft_pkg::SLOT_W-1:0]  r_out_slot;
    logic                        r_out_evict;

    logic [PAGE_W-1:0]  in_page;
    logic [PAGE_W-1:0]  cur_page;
    logic [OFS_W-1:0]   cur_ofs;
    logic               hit;
    logic [TLB_W-1:0]   hit_slot;
    logic               pm_valid;
    logic               fault;
    logic               need_evict;
    logic [FRAME_W-1:0] frame;
    logic [TLB_W-1:0]   slot;
    logic [31:0]        pa_wide;
    logic [31:0]        slot_wide;
    logic               out_free;

    assign in_page  = i_virtual_address[tft_pkg::VA_W-1:OFS_W];
    assign cur_page = r_va[tft_pkg::VA_W-1:OFS_W];
    assign cur_ofs  = r_va[OFS_W-1:0];

    always_comb begin
        hit_slot = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (r_match[i]) hit_slot = hit_slot | TLB_W'(i);
        end
    end

    assign hit        = |r_match;
    assign pm_valid   = r_pm_rd[FRAME_W];
    assign fault      = !hit && !pm_valid;
    assign need_evict = fault && r_wrap;
    assign frame      = hit ? r_tlb_frame[hit_slot] :
                        (pm_valid ? r_pm_rd[FRAME_W-1:0] : r_fptr);
    assign slot       = hit ? hit_slot : r_tptr;
    assign pa_wide    = 32'({frame, cur_ofs});
    assign slot_wide  = 32'(slot);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_status.clear_last = (r_clr == PAGE_LAST);
    assign o_status.need_evict = need_evict;
    assign o_status.out_free   = out_free;

    // page map: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_page_map[r_clr] <= '0;
        end else if (i_cmd.finish && fault) begin
            r_page_map[cur_page] <= {1'b1, r_fptr};
        end else if (i_cmd.evict) begin
            r_page_map[r_own_rd] <= '0;
        end
        if (i_cmd.accept) r_pm_rd <= r_page_map[in_page];
    end

    // frame owner: entry at r_fptr is only meaningful once the pointer has wrapped
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && fault) r_frame_owner[r_fptr] <= cur_page;
        if (i_cmd.accept) r_own_rd <= r_frame_owner[r_fptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_va <= i_virtual_address;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_match[i] <= r_tlb_valid[i] && (r_tlb_tag[i] == in_page);
            end
        end
        if (i_cmd.finish && !hit) begin
            r_tlb_tag[r_tptr]   <= cur_page;
            r_tlb_frame[r_tptr] <= frame;
        end
        if (i_cmd.finish) begin
            r_out_pa    <= pa_wide[tft_pkg::PA_W-1:0];
            r_out_hit   <= hit;
            r_out_fault <= fault;
            r_out_slot  <= slot_wide[tft_pkg::SLOT_W-1:0];
            r_out_evict <= need_evict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TLB_ENTRIES; i++) r_tlb_valid[i] <= 1'b0;
            r_tptr      <= '0;
            r_fptr      <= '0;
            r_wrap      <= 1'b0;
            r_clr       <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr <= r_clr + PAGE_W'(1);
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish && hit && (r_hit_cnt != tft_pkg::CNT_MAX)) begin
                r_hit_cnt <= r_hit_cnt + tft_pkg::CNT_W'(1);
            end
            if (i_cmd.finish && !hit) begin
                for (int i = 0; i < TLB_ENTRIES; i++) begin
                    if (TLB_W'(i) == r_tptr) begin
                        r_tlb_valid[i] <= 1'b1;
                    end else if (need_evict && (r_tlb_tag[i] == r_own_rd)) begin
                        r_tlb_valid[i] <= 1'b0;
                    end
                end
                r_tptr <= (r_tptr == TLB_LAST) ? '0 : r_tptr + TLB_W'(1);
            end
            if (i_cmd.finish && fault) begin
                r_fptr <= (r_fptr == FRAME_LAST) ? '0 : r_fptr + FRAME_W'(1);
                if (r_fptr == FRAME_LAST) r_wrap <= 1'b1;
                if (r_fault_cnt != tft_pkg::CNT_MAX) begin
                    r_fault_cnt <= r_fault_cnt + tft_pkg::CNT_W'(1);
                end
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_out_pa;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_tlb_slot         = r_out_slot;
    assign o_evicted_valid    = r_out_evict;
    assign o_hit_total        = r_hit_cnt;
    assign o_fault_total      = r_fault_cnt;

`ifndef ASSERT_OFF
    a_tlb_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> $onehot0(r_match))
        else $error("duplicate TLB tag match");
    a_evict_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_evict |-> r_out_fault && !r_out_hit)
        else $error("eviction without fault");
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && hit && (r_hit_cnt != tft_pkg::CNT_MAX)
        |=> r_hit_cnt == $past(r_hit_cnt) + tft_pkg::CNT_W'(1))
        else $error("hit counter not advanced");
    a_evict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && need_evict |=> i_cmd.evict)
        else $error("eviction write-back skipped");
`endif

endmodule

/* rtl/tlb_fifo_page_translator.sv */
// Top level of the TLB / FIFO page translator.
// Joins the sequencer (tft_ctrl) and the datapath (tft_dp). Depends on tft_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one virtual address per transaction.
//   Output channel: o_out_valid / i_out_stall carry one result per transaction.
//   A transaction is taken on a rising edge with valid high and stall low.
//   After reset the page map is cleared one entry a cycle, all PAGE_COUNT entries
//   (65536 / PAGE_BYTES, 256 at the default), with o_in_stall high.
//   The result register loads from the lookup state after the input transaction, once free.
//   Each address passes through the idle and lookup states on a TLB or page-map hit
//   and on a fault into a free frame; a fault that evicts a page adds the evict state,
//   for the second write through the page map's single write port.
//   The next address is taken while a result waits; if the receiver stalls, the
//   lookup holds until the result register frees up, then input stalls as well.
module tlb_fifo_page_translator #(
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 128,
    parameter int PAGE_BYTES  = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [tft_pkg::VA_W-1:0]   i_virtual_address,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [tft_pkg::PA_W-1:0]   o_physical_address,
    output logic                       o_tlb_hit,
    output logic                       o_page_fault,
    output logic [tft_pkg::SLOT_W-1:0] o_tlb_slot,
    output logic                       o_evicted_valid,
    output logic [tft_pkg::CNT_W-1:0]  o_hit_total,
    output logic [tft_pkg::CNT_W-1:0]  o_fault_total
);

    tft_pkg::t_cmd    cmd;
    tft_pkg::t_status status;

    tft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tft_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_virtual_address  (i_virtual_address),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_tlb_slot         (o_tlb_slot),
        .o_evicted_valid    (o_evicted_valid),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

endmodule

/* bench/tb.sv */
// Self-checking bench for tlb_fifo_page_translator: a directed table, then random
// address streams over a drifting hot region of pages.
// Depends on tft_pkg and the translator RTL; expected results come from the typed table rows or an in-bench model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TLB_N  = 16;
    localparam int FRAMES = 128;
    localparam int PAGES  = 256;
    localparam int PLAN_N = 25;

    typedef struct packed {
        logic [tft_pkg::PA_W-1:0]   pa;
        logic                       hit;
        logic                       fault;
        logic [tft_pkg::SLOT_W-1:0] slot;
        logic                       evicted;
        logic [tft_pkg::CNT_W-1:0]  hit_total;
        logic [tft_pkg::CNT_W-1:0]  fault_total;
    } t_xlat;

    typedef struct packed {
        logic [tft_pkg::VA_W-1:0] va;
        logic                     typed;
        t_xlat                    want;
    } t_plan_row;

    localparam t_xlat NO_WANT = '0;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [tft_pkg::VA_W-1:0]   i_virtual_address = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [tft_pkg::PA_W-1:0]   o_physical_address;
    logic                       o_tlb_hit;
    logic                       o_page_fault;
    logic [tft_pkg::SLOT_W-1:0] o_tlb_slot;
    logic                       o_evicted_valid;
    logic [tft_pkg::CNT_W-1:0]  o_hit_total;
    logic [tft_pkg::CNT_W-1:0]  o_fault_total;

    tlb_fifo_page_translator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_virtual_address  (i_virtual_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_tlb_slot         (o_tlb_slot),
        .o_evicted_valid    (o_evicted_valid),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

    always #6 i_clk = ~i_clk;

    // translation model state
    logic                      tlb_ok [TLB_N];
    logic [7:0]                tlb_page [TLB_N];
    logic [6:0]                tlb_frame [TLB_N];
    logic [3:0]                tlb_fill_ptr;
    logic                      map_ok [PAGES];
    logic [6:0]                map_frame [PAGES];
    logic                      owner_ok [FRAMES];
    logic [7:0]                owner_page [FRAMES];
    logic [6:0]                next_frame;
    logic [tft_pkg::CNT_W-1:0] seen_hits;
    logic [tft_pkg::CNT_W-1:0] seen_faults;

    t_xlat       pending [$];
    t_plan_row   plan [PLAN_N];
    int unsigned idle_pct = 26;
    int unsigned mismatch_count = 0;

    function automatic t_xlat translate_address(input logic [tft_pkg::VA_W-1:0] va);
        t_xlat      r;
        logic [7:0] page;
        logic [7:0] gone;
        logic [6:0] frame;
        r = '0;
        page = va[15:8];
        frame = '0;
        for (int i = 0; i < TLB_N; i++) begin
            if (tlb_ok[i] && tlb_page[i] == page) begin
                r.hit = 1'b1;
                r.slot = 4'(i);
                frame = tlb_frame[i];
            end
        end
        if (r.hit) begin
            if (seen_hits != tft_pkg::CNT_MAX) seen_hits++;
        end else begin
            if (map_ok[page]) begin
                frame = map_frame[page];
            end else begin
                r.fault = 1'b1;
                frame = next_frame;
                if (owner_ok[frame]) begin
                    r.evicted = 1'b1;
                    gone = owner_page[frame];
                    map_ok[gone] = 1'b0;
                    for (int i = 0; i < TLB_N; i++) begin
                        if (tlb_ok[i] && tlb_page[i] == gone) tlb_ok[i] = 1'b0;
                    end
                end
                owner_ok[frame] = 1'b1;
                owner_page[frame] = page;
                map_ok[page] = 1'b1;
                map_frame[page] = frame;
                next_frame++;
                if (seen_faults != tft_pkg::CNT_MAX) seen_faults++;
            end
            r.slot = tlb_fill_ptr;
            tlb_ok[tlb_fill_ptr] = 1'b1;
            tlb_page[tlb_fill_ptr] = page;
            tlb_frame[tlb_fill_ptr] = frame;
            tlb_fill_ptr++;
        end
        r.pa = {frame, va[7:0]};
        r.hit_total = seen_hits;
        r.fault_total = seen_faults;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
        mismatch_count++;
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
    endtask

    task automatic send_address(input logic [tft_pkg::VA_W-1:0] va, input logic typed,
                                input t_xlat want);
        t_xlat model;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_virtual_address <= va;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model = translate_address(va);
        pending.push_back(typed ? want : model);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_xlat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                note_mismatch("unexpected transaction", 32'(o_physical_address), 0);
            end else begin
                want = pending.pop_front();
                if (o_physical_address != want.pa)
                    note_mismatch("physical_address", 32'(o_physical_address),
                                  32'(want.pa));
                if (o_tlb_hit != want.hit)
                    note_mismatch("tlb_hit", 32'(o_tlb_hit), 32'(want.hit));
                if (o_page_fault != want.fault)
                    note_mismatch("page_fault", 32'(o_page_fault), 32'(want.fault));
                if (o_tlb_slot != want.slot)
                    note_mismatch("tlb_slot", 32'(o_tlb_slot), 32'(want.slot));
                if (o_evicted_valid != want.evicted)
                    note_mismatch("evicted_valid", 32'(o_evicted_valid),
                                  32'(want.evicted));
                if (o_hit_total != want.hit_total)
                    note_mismatch("hit_total", 32'(o_hit_total), 32'(want.hit_total));
                if (o_fault_total != want.fault_total)
                    note_mismatch("fault_total", 32'(o_fault_total),
                                  32'(want.fault_total));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [7:0]  hot;
        logic [7:0]  page;
        logic [7:0]  ofs;
        int unsigned sel;

        for (int i = 0; i < TLB_N; i++) begin
            tlb_ok[i] = 1'b0;
            tlb_page[i] = '0;
            tlb_frame[i] = '0;
        end
        for (int i = 0; i < PAGES; i++) begin
            map_ok[i] = 1'b0;
            map_frame[i] = '0;
        end
        for (int i = 0; i < FRAMES; i++) begin
            owner_ok[i] = 1'b0;
            owner_page[i] = '0;
        end
        tlb_fill_ptr = '0;
        next_frame = '0;
        seen_hits = '0;
        seen_faults = '0;

        // typed rows: va, typed, pa, hit, fault, slot, evicted, hit_total, fault_total
        plan[0]  = {16'h0000, 1'b1, 15'h0000, 1'b0, 1'b1, 4'd0, 1'b0, 16'd0, 16'd1};
        plan[1]  = {16'h00FF, 1'b1, 15'h00FF, 1'b1, 1'b0, 4'd0, 1'b0, 16'd1, 16'd1};
        plan[2]  = {16'hFFFF, 1'b1, 15'h01FF, 1'b0, 1'b1, 4'd1, 1'b0, 16'd1, 16'd2};
        plan[3]  = {16'hFF00, 1'b1, 15'h0100, 1'b1, 1'b0, 4'd1, 1'b0, 16'd2, 16'd2};
        plan[4]  = {16'h8000, 1'b1, 15'h0200, 1'b0, 1'b1, 4'd2, 1'b0, 16'd2, 16'd3};
        plan[5]  = {16'h7FFF, 1'b1, 15'h03FF, 1'b0, 1'b1, 4'd3, 1'b0, 16'd2, 16'd4};
        plan[6]  = {16'h5555, 1'b0, NO_WANT};
        plan[7]  = {16'hAAAA, 1'b0, NO_WANT};
        // fill the rest of the TLB and wrap its pointer
        plan[8]  = {16'h0180, 1'b0, NO_WANT};
        plan[9]  = {16'h0233, 1'b0, NO_WANT};
        plan[10] = {16'h03CC, 1'b0, NO_WANT};
        plan[11] = {16'h0401, 1'b0, NO_WANT};
        plan[12] = {16'h05FE, 1'b0, NO_WANT};
        plan[13] = {16'h0610, 1'b0, NO_WANT};
        plan[14] = {16'h07EF, 1'b0, NO_WANT};
        plan[15] = {16'h0800, 1'b0, NO_WANT};
        plan[16] = {16'h09FF, 1'b0, NO_WANT};
        plan[17] = {16'h0A5A, 1'b0, NO_WANT};
        plan[18] = {16'h0BA5, 1'b0, NO_WANT};
        plan[19] = {16'h0C3C, 1'b0, NO_WANT};
        // pages pushed out of the TLB but still mapped, plus a TLB hit (0x0100) and a new page (0x1234)
        plan[20] = {16'h0012, 1'b0, NO_WANT};
        plan[21] = {16'hFFFF, 1'b0, NO_WANT};
        plan[22] = {16'h0100, 1'b0, NO_WANT};
        plan[23] = {16'h8080, 1'b0, NO_WANT};
        plan[24] = {16'h1234, 1'b0, NO_WANT};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < PLAN_N; n++)
            send_address(plan[n].va, plan[n].typed, plan[n].want);

        // random streams with a drifting hot region of pages
        hot = 8'($urandom_range(255));
        for (int n = 0; n < 1700; n++) begin
            idle_pct = (n >= 600 && n < 900) ? 0 : 26;
            sel = $urandom_range(99);
            if (sel < 45) page = hot + 8'($urandom_range(11));
            else if (sel < 75) page = hot + 8'($urandom_range(95));
            else page = 8'($urandom_range(255));
            if ($urandom_range(49) == 0) hot = 8'($urandom_range(255));
            ofs = 8'($urandom_range(255));
            if ($urandom_range(15) == 0) ofs = $urandom_range(1) ? 8'hFF : 8'h00;
            send_address({page, ofs}, 1'b0, NO_WANT);
        end
        idle_pct = 26;

        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/tft_pkg.sv
rtl/tft_ctrl.sv
rtl/tft_dp.sv
rtl/tlb_fifo_page_translator.sv
bench/tb.sv
